FILE: design/spe_pkg.sv
// Package for the sparse polynomial evaluator: sizes, opcodes, front-to-back item type.
// No dependencies.
`timescale 1ns / 1ps
package spe_pkg;
    localparam int MaxTerms = 16;
    localparam int MaxVars  = 4;
    localparam int UseVars  = (MaxVars < 4) ? MaxVars : 4;
    localparam int TermW    = $clog2(MaxTerms);
    localparam int CountW   = $clog2(MaxTerms + 1);
    localparam int DataW    = 64;
    localparam int CfgW     = 5;
    localparam int QueueDepth = 2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;
    localparam logic [0:0] REG_TERM_COUNT = 1'b0;
    localparam logic [0:0] REG_VAR_COUNT  = 1'b1;

    typedef struct packed {
        logic [DataW-1:0] v0;
        logic [DataW-1:0] v1;
        logic [DataW-1:0] v2;
        logic [DataW-1:0] v3;
    } point_t;
endpackage

FILE: design/spe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module spe_ram #(
    parameter int Width = 64,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/spe_front.sv
// Front part: accepts items, writes loads into the term tables, queues evaluation points.
// Depends on spe_pkg and spe_ram.
`timescale 1ns / 1ps
module spe_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          op,
    input  logic [3:0]                    term_index,
    input  logic [spe_pkg::DataW-1:0]     coefficient,
    input  logic [spe_pkg::DataW-1:0]     exponent_0,
    input  logic [spe_pkg::DataW-1:0]     exponent_1,
    input  logic [spe_pkg::DataW-1:0]     exponent_2,
    input  logic [spe_pkg::DataW-1:0]     exponent_3,
    input  spe_pkg::point_t               point,
    output logic                          q_valid,
    output spe_pkg::point_t               q_point,
    input  logic                          q_take,
    input  logic [spe_pkg::TermW-1:0]     rd_term,
    output logic [spe_pkg::DataW-1:0]     rd_coef,
    output logic [spe_pkg::DataW-1:0]     rd_exp [spe_pkg::MaxVars]
);
    import spe_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    point_t           q_mem [QueueDepth];
    logic [PtrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]    cnt_reg;
    logic             accept, load_we;
    logic [DataW-1:0] exp_in [4];

    // hold loads until every queued point has been evaluated
    assign full    = (cnt_reg == (PtrW+1)'(QueueDepth)) ||
                     ((cnt_reg != '0) && (op == OP_LOAD));
    assign accept  = push && !full;
    // out-of-range slots are dropped
    assign load_we = accept && (op == OP_LOAD) && ({28'd0, term_index} < MaxTerms);
    assign exp_in[0] = exponent_0;
    assign exp_in[1] = exponent_1;
    assign exp_in[2] = exponent_2;
    assign exp_in[3] = exponent_3;

    spe_ram #(.Width(DataW), .Depth(MaxTerms)) u_coef (
        .clk(clk), .we(load_we), .waddr(term_index[TermW-1:0]), .wdata(coefficient),
        .raddr(rd_term), .rdata(rd_coef)
    );

    for (genvar v = 0; v < MaxVars; v++)
    begin : g_exp
        logic [DataW-1:0] wd;
        logic             we;
        assign wd = (v < UseVars) ? exp_in[v % 4] : '0;
        assign we = load_we && (v < UseVars);
        spe_ram #(.Width(DataW), .Depth(MaxTerms)) u_exp (
            .clk(clk), .we(we), .waddr(term_index[TermW-1:0]), .wdata(wd),
            .raddr(rd_term), .rdata(rd_exp[v])
        );
    end

    assign q_valid = (cnt_reg != '0);
    assign q_point = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (accept && op == OP_EVAL)
        begin
            q_mem[wr_ptr_reg] <= point;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (accept && op == OP_EVAL)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_take)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PtrW+1)'(accept && op == OP_EVAL) - (PtrW+1)'(q_take);
        end
    end
endmodule

FILE: design/spe_back.sv
// Back part: sequences terms and exponent bits, square-and-multiply with 4 lanes,
// a shared 64x64 low-half multiplier built from 32-bit partial products.
// Depends on spe_pkg.
`timescale 1ns / 1ps
module spe_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [4:0]                    term_count,
    input  logic [2:0]                    variable_count,
    input  logic                          q_valid,
    input  spe_pkg::point_t               q_point,
    output logic                          q_take,
    output logic [spe_pkg::TermW-1:0]     rd_term,
    input  logic [spe_pkg::DataW-1:0]     rd_coef,
    input  logic [spe_pkg::DataW-1:0]     rd_exp [spe_pkg::MaxVars],
    output logic                          empty,
    input  logic                          pop,
    output logic [spe_pkg::DataW-1:0]     poly_value
);
    import spe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_LOAD, S_BIT, S_MA, S_MB, S_MC, S_COMB, S_CA, S_CB, S_CC, S_ACC,
        S_DONE
    } state_t;

    localparam int VarW = $clog2(MaxVars + 1);
    localparam int LaneW = (MaxVars > 1) ? $clog2(MaxVars) : 1;

    state_t           state_reg;
    logic [CountW-1:0] terms, term_reg;
    logic [VarW-1:0]   vars;
    logic [5:0]        bit_reg;
    logic [LaneW:0]    lane_reg;
    logic              phase_reg;  // 0: acc*base, 1: base*base
    logic [DataW-1:0]  base_reg [MaxVars];
    logic [DataW-1:0]  acc_reg [MaxVars];
    logic [DataW-1:0]  exp_reg [MaxVars];
    logic [DataW-1:0]  prod_reg, sum_reg, out_reg;
    logic              out_full_reg;
    logic [DataW-1:0]  ma, mb;
    logic [DataW-1:0]  pll_reg;
    logic [31:0]       plh_reg, phl_reg;
    logic [DataW-1:0]  mres;
    logic [DataW-1:0]  vin [4];

    assign terms = (term_count > 5'(MaxTerms)) ? CountW'(MaxTerms) : CountW'(term_count);
    assign vars  = (3'(UseVars) < variable_count) ? VarW'(UseVars) : VarW'(variable_count);
    assign rd_term = term_reg[TermW-1:0];
    assign vin[0] = q_point.v0;
    assign vin[1] = q_point.v1;
    assign vin[2] = q_point.v2;
    assign vin[3] = q_point.v3;
    assign empty = !out_full_reg;
    assign poly_value = out_reg;
    assign q_take = (state_reg == S_DONE) && !out_full_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        if (state_reg == S_BIT || state_reg == S_MA || state_reg == S_MB || state_reg == S_MC)
        begin
            ma = phase_reg ? base_reg[lane_reg[LaneW-1:0]] : acc_reg[lane_reg[LaneW-1:0]];
            mb = base_reg[lane_reg[LaneW-1:0]];
        end
        else
        begin
            ma = prod_reg;
            mb = acc_reg[lane_reg[LaneW-1:0]];
        end
    end
    assign mres = pll_reg + {plh_reg + phl_reg, 32'd0};

    always_ff @(posedge clk)
    begin
        pll_reg <= ma[31:0] * mb[31:0];
        plh_reg <= ma[31:0] * mb[63:32];
        phl_reg <= ma[63:32] * mb[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_full_reg <= 1'b0;
            term_reg     <= '0;
            bit_reg      <= '0;
            lane_reg     <= '0;
            phase_reg    <= 1'b0;
        end
        else
        begin
            if (pop && out_full_reg)
            begin
                out_full_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        term_reg  <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= (term_reg == terms) ? S_DONE : S_LOAD;
                end
                S_LOAD:
                begin
                    // RAM data is valid now; start powers for all lanes
                    for (int v = 0; v < MaxVars; v++)
                    begin
                        base_reg[v] <= (v < UseVars) ? vin[v % 4] : '0;
                        acc_reg[v]  <= 64'd1;
                        exp_reg[v]  <= (VarW'(v) < vars) ? rd_exp[v] : '0;
                    end
                    prod_reg  <= rd_coef;
                    bit_reg   <= '0;
                    lane_reg  <= '0;
                    phase_reg <= 1'b0;
                    state_reg <= S_BIT;
                end
                S_BIT:
                begin
                    // skip the multiply when this exponent bit is clear
                    if (!phase_reg && !exp_reg[lane_reg[LaneW-1:0]][bit_reg])
                    begin
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_MA;
                    end
                end
                S_MA: state_reg <= S_MB;
                S_MB: state_reg <= S_MC;
                S_MC:
                begin
                    if (phase_reg)
                    begin
                        base_reg[lane_reg[LaneW-1:0]] <= mres;
                        phase_reg <= 1'b0;
                        if (lane_reg == (LaneW+1)'(MaxVars - 1))
                        begin
                            lane_reg <= '0;
                            if (bit_reg == 6'd63)
                            begin
                                state_reg <= S_COMB;
                            end
                            else
                            begin
                                bit_reg   <= bit_reg + 1'b1;
                                state_reg <= S_BIT;
                            end
                        end
                        else
                        begin
                            lane_reg  <= lane_reg + 1'b1;
                            state_reg <= S_BIT;
                        end
                    end
                    else
                    begin
                        acc_reg[lane_reg[LaneW-1:0]] <= mres;
                        phase_reg <= 1'b1;
                        state_reg <= S_BIT;
                    end
                end
                S_COMB: state_reg <= S_CA;
                S_CA: state_reg <= S_CB;
                S_CB: state_reg <= S_CC;
                S_CC:
                begin
                    prod_reg <= mres;
                    if (lane_reg == (LaneW+1)'(MaxVars - 1))
                    begin
                        lane_reg  <= '0;
                        state_reg <= S_ACC;
                    end
                    else
                    begin
                        lane_reg  <= lane_reg + 1'b1;
                        state_reg <= S_COMB;
                    end
                end
                S_ACC:
                begin
                    sum_reg   <= sum_reg + prod_reg;
                    term_reg  <= term_reg + 1'b1;
                    state_reg <= S_READ;
                end
                S_DONE:
                begin
                    if (!out_full_reg)
                    begin
                        out_reg      <= sum_reg;
                        out_full_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/sparse_polynomial_evaluator.sv
// Top level of the sparse polynomial evaluator: config registers, front and back parts.
// Depends on spe_pkg, spe_front, spe_back.
//
//  port group      dir   transfer when
//  input item      in    push && !full
//  result          out   pop && !empty
//  config write    in    cfg_we
//
// Every product runs through one shared 64-bit multiplier.
// Loads are written into the term tables and give no result.
// A 2-entry point queue lets new points enter while the back part works; loads are held
// off (full) until every queued point has finished, so they never change a pending result.
// Reset sets term_count to 0 and variable_count to 4; the term tables are not cleared.
`timescale 1ns / 1ps
module sparse_polynomial_evaluator (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [spe_pkg::CfgW-1:0]  cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic                      op,
    input  logic [3:0]                term_index,
    input  logic [63:0]               coefficient,
    input  logic [63:0]               exponent_0,
    input  logic [63:0]               exponent_1,
    input  logic [63:0]               exponent_2,
    input  logic [63:0]               exponent_3,
    input  logic [63:0]               value_0,
    input  logic [63:0]               value_1,
    input  logic [63:0]               value_2,
    input  logic [63:0]               value_3,
    output logic                      empty,
    input  logic                      pop,
    output logic [63:0]               poly_value
);
    import spe_pkg::*;

    logic [4:0]       term_count_reg;
    logic [2:0]       var_count_reg;
    point_t           point, q_point;
    logic             q_valid, q_take;
    logic [TermW-1:0] rd_term;
    logic [DataW-1:0] rd_coef;
    logic [DataW-1:0] rd_exp [MaxVars];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= '0;
            var_count_reg  <= 3'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TERM_COUNT: term_count_reg <= cfg_data[4:0];
                REG_VAR_COUNT:  var_count_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign point = '{v0: value_0, v1: value_1, v2: value_2, v3: value_3};

    spe_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .op(op),
        .term_index(term_index), .coefficient(coefficient),
        .exponent_0(exponent_0), .exponent_1(exponent_1),
        .exponent_2(exponent_2), .exponent_3(exponent_3),
        .point(point), .q_valid(q_valid), .q_point(q_point), .q_take(q_take),
        .rd_term(rd_term), .rd_coef(rd_coef), .rd_exp(rd_exp)
    );

    spe_back u_back (
        .clk(clk), .rst_n(rst_n), .term_count(term_count_reg),
        .variable_count(var_count_reg), .q_valid(q_valid), .q_point(q_point),
        .q_take(q_take), .rd_term(rd_term), .rd_coef(rd_coef), .rd_exp(rd_exp),
        .empty(empty), .pop(pop), .poly_value(poly_value)
    );
endmodule
